// ===== design/cbu8_pkg.sv =====
package cbu8_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int VAL_W      = 32;
  localparam int ACC_W      = 35;
  localparam int QW         = FRAC_BITS + 4;
  localparam int DW         = VAL_W + FRAC_BITS + 4;
  localparam int HI_W       = DW - QW;
  localparam int RES_W      = 20;
  localparam int OUT_DATA_W = 24;
  localparam int STEP_W     = $clog2(QW + 1);

  localparam logic [VAL_W-1:0] ONE_FX   = VAL_W'(64'd1 << FRAC_BITS);
  localparam logic [63:0]      CAP_FULL = 64'd8 << FRAC_BITS;
  localparam logic [RES_W-1:0] RES_CAP  =
    (CAP_FULL > 64'hFFFFF) ? {RES_W{1'b1}} : RES_W'(CAP_FULL);

  localparam logic [3:0] PH_MID = 4'd7;
  localparam logic [3:0] PH_FIN = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MWB,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MARG,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [HI_W-1:0]  hi;
    logic [QW-1:0]    lo;
    logic [ACC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

  // entry scaled by the k-th product of an item
  function automatic logic [2:0] scale_idx(input logic [3:0] ph, input logic [1:0] k);
    logic [2:0] r;
    r = 3'd0;
    case (ph) inside
      [4'd0:4'd1]:  r = {k[1], ph[0], k[0]};
      [4'd4:4'd7]:  r = {ph[0], k[0], ph[1]};
      [4'd8:4'd11]: r = {ph[1:0], k[0]};
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] num_ops(input logic [3:0] ph);
    logic [2:0] r;
    r = 3'd0;
    case (ph) inside
      [4'd0:4'd1]:  r = 3'd4;
      [4'd4:4'd11]: r = 3'd2;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  // entries summed into result j
  function automatic logic [7:0] marg_mask(input logic fin, input logic [2:0] j);
    logic [7:0] r;
    r = 8'h00;
    case ({fin, j})
      4'b0000: r = 8'b0000_0011;
      4'b0001: r = 8'b0000_1100;
      4'b0010: r = 8'b0011_0000;
      4'b0011: r = 8'b1100_0000;
      4'b1000: r = 8'b0000_0101;
      4'b1001: r = 8'b0000_1010;
      4'b1010: r = 8'b0101_0000;
      4'b1011: r = 8'b1010_0000;
      4'b1100: r = 8'b0011_0011;
      4'b1101: r = 8'b1100_1100;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== design/clique_belief_update_8.sv =====
// items 2 and 3 only advance the phase; other items multiply once per product
//   (4 products for items 0-1, 2 for items 4-11) through one shared multiplier
// items 7 and 11 then sum the 8 entries, divide each by the sum (radix-2 division,
//   skipped when the sum is zero) and sum each result before waiting on the output
// one item at a time; after items 7 and 11, the next waits for the last result
// reset: synchronous active-low; potential returns to all ones, phase to zero
module clique_belief_update_8 import cbu8_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VAL_W-1:0]      in_tdata,   // value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // value_res, zero pad
  output logic                  out_tuser,  // port
  output logic                  out_tlast   // last
);

  state_t           state_r, state_nxt;
  logic [3:0]       phase_r, phase_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [2:0]       j_r, j_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] sum_r, sum_nxt;
  logic [VAL_W-1:0] m_r, m_nxt;
  logic [RES_W-1:0] res_r, res_nxt;
  logic             port_r, port_nxt;
  logic             last_r, last_nxt;
  logic [VAL_W-1:0] pot_r [8];

  logic             pot_we;
  logic             pot_ones;
  logic [2:0]       pot_waddr;
  logic [VAL_W-1:0] pot_wdata;
  logic [2:0]       rd_idx;
  logic [VAL_W-1:0] pot_rd;
  logic [2:0]       nops;
  logic [2:0]       sidx;
  logic [7:0]       mask;
  logic             fin;
  logic [VAL_W-1:0] addend;
  logic [ACC_W-1:0] acc_add;
  logic [RES_W-1:0] capped;
  logic [DW-1:0]    dvd;
  logic             mul_en;
  logic [VAL_W-1:0] mul_res;
  logic             div_start;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  cbu8_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (pot_rd),
    .b   (m_r),
    .res (mul_res)
  );

  cbu8_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    fin     = (phase_r == PH_FIN);
    nops    = num_ops(phase_r);
    sidx    = scale_idx(phase_r, k_r);
    mask    = marg_mask(fin, j_r);
    rd_idx  = (state_r == ST_MUL) ? sidx : cnt_r;
    pot_rd  = pot_r[rd_idx];
    addend  = (state_r == ST_SUM || mask[cnt_r]) ? pot_rd : '0;
    acc_add = acc_r + ACC_W'(addend);
    capped  = (acc_add > ACC_W'(RES_CAP)) ? RES_CAP : acc_add[RES_W-1:0];
    dvd     = (DW'(pot_rd) << (FRAC_BITS + 3)) + DW'(sum_r >> 1);
    div_req.start   = div_start;
    div_req.hi      = dvd[DW-1:QW];
    div_req.lo      = dvd[QW-1:0];
    div_req.divisor = sum_r;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    m_nxt         = m_r;
    res_nxt       = res_r;
    port_nxt      = port_r;
    last_nxt      = last_r;
    pot_we        = 1'b0;
    pot_ones      = 1'b0;
    pot_waddr     = cnt_r;
    pot_wdata     = mul_res;
    mul_en        = 1'b0;
    div_start     = 1'b0;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          m_nxt = in_tdata;
          k_nxt = 2'd0;
          if (nops != 3'd0) begin
            state_nxt = ST_MUL;
          end else begin
            phase_nxt = phase_r + 4'd1;
          end
        end
      end
      ST_MUL: begin
        mul_en    = 1'b1;
        state_nxt = ST_MWB;
      end
      ST_MWB: begin
        pot_we    = 1'b1;
        pot_waddr = sidx;
        pot_wdata = mul_res;
        if ({1'b0, k_r} == nops - 3'd1) begin
          if (phase_r == PH_MID || fin) begin
            acc_nxt   = '0;
            cnt_nxt   = 3'd0;
            state_nxt = ST_SUM;
          end else begin
            phase_nxt = phase_r + 4'd1;
            state_nxt = ST_IDLE;
          end
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_SUM: begin
        acc_nxt = acc_add;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          sum_nxt = acc_add;
          if (acc_add == '0) begin
            pot_ones  = 1'b1;
            acc_nxt   = '0;
            j_nxt     = 3'd0;
            state_nxt = ST_MARG;
          end else begin
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          pot_we    = 1'b1;
          pot_waddr = cnt_r;
          pot_wdata = VAL_W'(div_rsp.quot);
          cnt_nxt   = cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            acc_nxt   = '0;
            j_nxt     = 3'd0;
            state_nxt = ST_MARG;
          end else begin
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_MARG: begin
        acc_nxt = acc_add;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          res_nxt   = capped;
          port_nxt  = fin && !j_r[2];
          last_nxt  = fin ? (j_r == 3'd7) : (j_r == 3'd3);
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          if (last_r) begin
            if (fin) begin
              pot_ones  = 1'b1;
              phase_nxt = 4'd0;
            end else begin
              phase_nxt = phase_r + 4'd1;
            end
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + 3'd1;
            acc_nxt   = '0;
            cnt_nxt   = 3'd0;
            state_nxt = ST_MARG;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 4'd0;
      k_r     <= 2'd0;
      cnt_r   <= 3'd0;
      j_r     <= 3'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    m_r    <= m_nxt;
    res_r  <= res_nxt;
    port_r <= port_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || pot_ones) begin
      for (int i = 0; i < 8; i++) begin
        pot_r[i] <= ONE_FX;
      end
    end else if (pot_we) begin
      pot_r[pot_waddr] <= pot_wdata;
    end
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, res_r};
  assign out_tuser  = port_r;
  assign out_tlast  = last_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < 4'd12)
    else $error("phase out of range");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV_WAIT)
    else $error("divider finished outside of wait state");

  a_port1_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tlast)
    else $error("port 1 word marked last");

endmodule

// ===== design/cbu8_mul.sv =====
module cbu8_mul import cbu8_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic [VAL_W-1:0] res
);

  logic [2*VAL_W-1:0] prod_r;
  logic [2*VAL_W:0]   rnd;
  logic [2*VAL_W:0]   shd;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  // round half up, then saturate
  always_comb begin
    rnd = {1'b0, prod_r} + ((2*VAL_W+1)'(1) << (FRAC_BITS - 1));
    shd = rnd >> FRAC_BITS;
    res = (|shd[2*VAL_W:VAL_W]) ? {VAL_W{1'b1}} : shd[VAL_W-1:0];
  end

endmodule

// ===== design/cbu8_div.sv =====
module cbu8_div import cbu8_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ACC_W-1:0]  rem_r, rem_nxt;
  logic [ACC_W-1:0]  dvs_r, dvs_nxt;
  logic [QW-1:0]     lo_r, lo_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [ACC_W:0]    rem_sh;
  logic [ACC_W:0]    rem_sub;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r, lo_r[QW-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(QW);
      rem_nxt  = ACC_W'(req.hi);
      dvs_nxt  = req.divisor;
      lo_nxt   = req.lo;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
      q_nxt    = {q_r[QW-2:0], ge};
      lo_nxt   = lo_r << 1;
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule
